// ===== src/imaadpcm_pkg.sv =====
// Shared types, constants and step table for the stereo IMA ADPCM block decoder.
package imaadpcm_pkg;

  // Largest step index of the IMA step table
  localparam int unsigned STEP_INDEX_MAX = 88;
  localparam int unsigned STEP_TABLE_DEPTH = STEP_INDEX_MAX + 1;

  // Bytes taken by the two channel headers at the start of a block
  localparam int unsigned HEADER_BYTES = 8;

  // Default upper bound on the block length
  localparam int unsigned MAX_BLOCK_BYTES_DEFAULT = 4096;

  localparam int unsigned BLOCK_ALIGN_W = 13;
  localparam logic [BLOCK_ALIGN_W-1:0] BLOCK_ALIGN_RESET = 13'd2048;

  // Position of a byte within its four-byte channel header
  localparam logic [1:0] HDR_PRED_LOW  = 2'd0;
  localparam logic [1:0] HDR_PRED_HIGH = 2'd1;
  localparam logic [1:0] HDR_STEP_IDX  = 2'd2;
  localparam logic [1:0] HDR_RESERVED  = 2'd3;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic [11:0]        sample_index;
    logic               last_of_item;
  } out_word_t;

  // IMA ADPCM quantizer step sizes
  localparam logic [14:0] STEP_TABLE [STEP_TABLE_DEPTH] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

endpackage

// ===== src/imaadpcm_nibble.sv =====
// One 4-bit IMA ADPCM code: predictor update with saturation and step index adaptation.
module imaadpcm_nibble
  import imaadpcm_pkg::*;
(
  input  logic signed [15:0] pred_in,
  input  logic [6:0]         idx_in,
  input  logic [3:0]         code,
  output logic signed [15:0] pred_out,
  output logic [6:0]         idx_out
);

  logic [6:0]         si;
  logic [16:0]        step;
  logic [16:0]        diff;
  logic [2:0]         mag;
  logic signed [17:0] val;
  logic signed [7:0]  delta;
  logic signed [7:0]  ni;

  always_comb begin
    // out-of-range index falls back to the first step
    si   = (32'(idx_in) > STEP_INDEX_MAX) ? 7'd0 : idx_in;
    step = {2'b00, STEP_TABLE[si]};
    mag  = code[2:0];

    // bit-tested step sum
    diff = (mag[2] ? step : 17'd0)
         + (mag[1] ? (step >> 1) : 17'd0)
         + (mag[0] ? (step >> 2) : 17'd0)
         + (step >> 3);

    // add or subtract, then saturate to 16 bits
    if (code[3]) begin
      val = {{2{pred_in[15]}}, pred_in} - $signed({1'b0, diff});
      if (val < -18'sd32768) val = -18'sd32768;
    end else begin
      val = {{2{pred_in[15]}}, pred_in} + $signed({1'b0, diff});
      if (val > 18'sd32767) val = 18'sd32767;
    end
    pred_out = val[15:0];

    // index adaptation: -1 for small codes, 2*mag-6 otherwise
    delta = mag[2] ? ($signed({4'b0000, mag, 1'b0}) - 8'sd6) : -8'sd1;
    ni    = $signed({1'b0, si}) + delta;
    if (ni < 8'sd0) begin
      idx_out = 7'd0;
    end else if (ni > $signed(8'(STEP_INDEX_MAX))) begin
      idx_out = 7'(STEP_INDEX_MAX);
    end else begin
      idx_out = ni[6:0];
    end
  end

endmodule

// ===== src/ima_adpcm_stereo_block_decoder.sv =====
// Top level of the stereo IMA ADPCM block decoder: byte intake, block position and output word.
//
//   port group   dir  handshake          word
//   in_*         in   in_valid/in_stall   in_word_t  (data_byte, last_byte)
//   out_*        out  out_valid/out_stall out_word_t (sample, channel, sample_index, last_of_item)
//   cfg_*        in   cfg_valid/cfg_ready block_align, 13 bits
//
// A data byte stays in the decode stage while each of its nibbles is decoded in turn, so data runs at
// one sample per clock unless the output stalls; the shared nibble decoder and the per-channel predictor sets the rate.
// Header bytes need no nibble pass; the reserved header byte emits the header sample.
// A new byte is taken in the cycle the previous one finishes. Output stall holds the
// result register and backs up into in_stall. rst is synchronous; it clears block position,
// channel state and block_align back to 2048. cfg_ready is always high.
module ima_adpcm_stereo_block_decoder
  import imaadpcm_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_word_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_word_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [BLOCK_ALIGN_W-1:0] cfg_data
);

  localparam int unsigned POS_W = $clog2(MAX_BLOCK_BYTES);
  localparam int unsigned LEN_W = (POS_W + 1 > BLOCK_ALIGN_W) ? POS_W + 1 : BLOCK_ALIGN_W;

  // Configuration and block state
  logic [BLOCK_ALIGN_W-1:0] block_align;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         pos_next;
  logic signed [15:0]       predictor [2];
  logic [6:0]               step_index [2];
  logic [7:0]               header_low;

  // Decode stage
  in_word_t                 hold;
  logic                     hold_valid;
  logic                     phase;

  // Combinational
  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         pos_inc;
  logic                     hdr;
  logic [POS_W-1:0]         dpos;
  logic                     ch;
  logic [3:0]               nib;
  logic                     has_result;
  logic                     advance;
  logic                     fire;
  logic                     item_done;
  logic                     accept;
  logic signed [15:0]       dec_pred;
  logic [6:0]               dec_idx;
  logic [31:0]              idx_wide;
  out_word_t                result;

  imaadpcm_nibble u_nibble (
    .pred_in  (predictor[ch]),
    .idx_in   (step_index[ch]),
    .code     (nib),
    .pred_out (dec_pred),
    .idx_out  (dec_idx)
  );

  assign cfg_ready = 1'b1;

  // Block length clamp and next byte position
  always_comb begin
    if (32'(block_align) > MAX_BLOCK_BYTES) begin
      len = LEN_W'(MAX_BLOCK_BYTES);
    end else begin
      len = LEN_W'(block_align);
    end
    pos_inc = LEN_W'(pos) + LEN_W'(1);
    if (hold.last_byte || pos_inc >= len) begin
      pos_next = '0;
    end else begin
      pos_next = pos_inc[POS_W-1:0];
    end
  end

  // Byte classification and handshake
  always_comb begin
    hdr        = (32'(pos) < HEADER_BYTES);
    dpos       = pos - POS_W'(HEADER_BYTES);
    ch         = hdr ? pos[2] : dpos[2];
    nib        = phase ? hold.data_byte[7:4] : hold.data_byte[3:0];
    has_result = !hdr || (pos[1:0] == HDR_RESERVED);
    advance    = !out_valid || !out_stall;
    fire       = hold_valid && (!has_result || advance);
    item_done  = fire && (hdr || phase);
    in_stall   = hold_valid && !item_done;
    accept     = in_valid && !in_stall;
  end

  // Result word
  always_comb begin
    idx_wide = ((32'(dpos >> 3) << 2) + 32'(dpos[1:0])) * 2 + 32'd1 + 32'(phase);
    result.channel = ch;
    if (hdr) begin
      result.sample       = predictor[ch];
      result.sample_index = 12'd0;
      result.last_of_item = 1'b1;
    end else begin
      result.sample       = dec_pred;
      result.sample_index = idx_wide[11:0];
      result.last_of_item = phase;
    end
  end

  // Control and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      block_align   <= BLOCK_ALIGN_RESET;
      pos           <= '0;
      predictor[0]  <= '0;
      predictor[1]  <= '0;
      step_index[0] <= '0;
      step_index[1] <= '0;
      header_low    <= '0;
      hold_valid    <= 1'b0;
      phase         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        block_align <= cfg_data;
      end

      if (accept) begin
        hold_valid <= 1'b1;
      end else if (item_done) begin
        hold_valid <= 1'b0;
      end

      if (fire) begin
        if (hdr) begin
          case (pos[1:0])
            HDR_PRED_LOW:  header_low <= hold.data_byte;
            HDR_PRED_HIGH: predictor[ch] <= {hold.data_byte, header_low};
            HDR_STEP_IDX: begin
              step_index[ch] <= (32'(hold.data_byte) > STEP_INDEX_MAX) ?
                                7'd0 : hold.data_byte[6:0];
            end
            default: ;
          endcase
        end else begin
          predictor[ch]  <= dec_pred;
          step_index[ch] <= dec_idx;
          phase          <= !phase;
        end
        if (item_done) begin
          pos <= pos_next;
        end
      end

      if (advance) begin
        out_valid <= fire && has_result;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// ===== sim/ima_adpcm_sample_checker.sv =====
// Checker for the stereo IMA ADPCM block decoder: predicts every PCM word and compares.
`timescale 1ns / 1ps

module ima_adpcm_sample_checker
  import imaadpcm_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  in_word_t                 in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  out_word_t                out_data,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [BLOCK_ALIGN_W-1:0] cfg_data,
  output int                       fail_count,
  output int                       pending
);

  // Shadow decoder state
  logic [BLOCK_ALIGN_W-1:0] align_reg;
  int unsigned              byte_pos;
  logic signed [15:0]       chan_pred [2];
  logic [6:0]               chan_step [2];
  logic [7:0]               pred_low;

  // PCM words still owed by the block, oldest first
  out_word_t pending_samples [$];
  int        mismatches;

  // Scratch for the per-edge work
  out_word_t          got;
  out_word_t          want;
  logic [7:0]         b;
  logic               ch;
  logic signed [15:0] smp;
  int unsigned        eff_len;
  int unsigned        d;
  int unsigned        grp;
  int unsigned        idx;

  assign fail_count = mismatches;

  function automatic out_word_t make_word(logic signed [15:0] s, logic c, int unsigned pos_idx,
                                          logic lst);
    out_word_t w;
    w.sample       = s;
    w.channel      = c;
    w.sample_index = pos_idx[11:0];
    w.last_of_item = lst;
    return w;
  endfunction

  // One nibble through the predictor: bit-tested step sum, saturation, index adaptation
  function automatic logic signed [15:0] adapt_nibble(logic c, logic [3:0] code);
    int si;
    int step;
    int delta;
    int acc;
    int mag;
    int nidx;
    si = chan_step[c];
    if (si > STEP_INDEX_MAX) si = 0;
    step  = STEP_TABLE[si];
    delta = 0;
    mag   = code[2:0];
    if (code[2]) delta += step;
    step = step >> 1;
    if (code[1]) delta += step;
    step = step >> 1;
    if (code[0]) delta += step;
    step = step >> 1;
    delta += step;
    acc = chan_pred[c];
    if (code[3]) begin
      acc -= delta;
      if (acc < -32768) acc = -32768;
    end else begin
      acc += delta;
      if (acc > 32767) acc = 32767;
    end
    nidx = si + ((mag < 4) ? -1 : 2 * mag - 6);
    if (nidx < 0) nidx = 0;
    if (nidx > STEP_INDEX_MAX) nidx = STEP_INDEX_MAX;
    chan_step[c] = nidx[6:0];
    chan_pred[c] = acc[15:0];
    return acc[15:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      align_reg    = BLOCK_ALIGN_RESET;
      byte_pos     = 0;
      chan_pred[0] = '0;
      chan_pred[1] = '0;
      chan_step[0] = '0;
      chan_step[1] = '0;
      pred_low     = '0;
      mismatches   = 0;
      pending_samples.delete();
    end else begin
      // Result side first, so a word leaving now never pairs with one entering now
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pending_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected word: sample %0d ch %0d idx %0d last %0d", $realtime,
                     got.sample, got.channel, got.sample_index, got.last_of_item);
        end else begin
          want = pending_samples.pop_front();
          if (got.sample !== want.sample || got.channel !== want.channel ||
              got.sample_index !== want.sample_index ||
              got.last_of_item !== want.last_of_item) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t mismatch: exp sample %0d ch %0d idx %0d last %0d, got %0d %0d %0d %0d",
                       $realtime, want.sample, want.channel, want.sample_index,
                       want.last_of_item, got.sample, got.channel, got.sample_index,
                       got.last_of_item);
          end
        end
      end

      if (cfg_valid && cfg_ready) align_reg = cfg_data;

      // Byte intake: header fields or two samples per data byte
      if (in_valid && !in_stall) begin
        b       = in_data.data_byte;
        eff_len = (align_reg > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : align_reg;
        if (byte_pos < HEADER_BYTES) begin
          ch = byte_pos[2];
          case (byte_pos[1:0])
            HDR_PRED_LOW:  pred_low = b;
            HDR_PRED_HIGH: chan_pred[ch] = {b, pred_low};
            HDR_STEP_IDX:  chan_step[ch] = (b > STEP_INDEX_MAX) ? 7'd0 : b[6:0];
            default:       pending_samples.push_back(make_word(chan_pred[ch], ch, 0, 1'b1));
          endcase
        end else begin
          d   = byte_pos - HEADER_BYTES;
          grp = d >> 2;
          ch  = grp[0];
          idx = (grp >> 1) * 4 + d[1:0];
          smp = adapt_nibble(ch, b[3:0]);
          pending_samples.push_back(make_word(smp, ch, 1 + 2 * idx, 1'b0));
          smp = adapt_nibble(ch, b[7:4]);
          pending_samples.push_back(make_word(smp, ch, 2 + 2 * idx, 1'b1));
        end
        byte_pos++;
        if (in_data.last_byte || byte_pos >= eff_len) byte_pos = 0;
      end
    end
    pending <= pending_samples.size();
  end

endmodule

// ===== sim/tb_ima_adpcm_stereo_block_decoder.sv =====
// Testbench top for the stereo IMA ADPCM block decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_ima_adpcm_stereo_block_decoder;
  import imaadpcm_pkg::*;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_word_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_word_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [BLOCK_ALIGN_W-1:0] cfg_data  = '0;

  int   fail_count;
  int   pending_cnt;
  int   send_pct  = 0;
  int   recv_pct  = 0;
  int   hold_left = 0;
  logic hold_go   = 1'b0;
  int   bytes_sent = 0;
  int   eff_len    = 2048;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ima_adpcm_stereo_block_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ima_adpcm_sample_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending_cnt)
  );

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 78; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 78; end
      default:   begin send_pct = 6;  recv_pct = 6;  end
    endcase
  endtask

  // Offer one byte word and wait for it to be taken; valid stays up afterwards
  task automatic push_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop sending and wait until every owed word is out, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_align(input logic [BLOCK_ALIGN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    eff_len = (v > MAX_BLOCK_BYTES_DEFAULT) ? MAX_BLOCK_BYTES_DEFAULT : v;
  endtask

  // Well-formed block start: headers with edge-heavy predictors, then biased data
  task automatic send_block(input int n, input bit mark_end);
    logic [15:0] pv;
    logic [7:0]  b;
    pv = '0;
    for (int i = 0; i < n; i++) begin
      if (i < HEADER_BYTES) begin
        case (i % 4)
          0: begin
            case ($urandom_range(0, 5))
              0:       pv = 16'h8000;
              1:       pv = 16'h7fff;
              2:       pv = 16'h0000;
              default: pv = 16'($urandom);
            endcase
            b = pv[7:0];
          end
          1: b = pv[15:8];
          2: b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(89, 255))
                                             : 8'($urandom_range(0, STEP_INDEX_MAX));
          default: b = 8'($urandom);
        endcase
      end else begin
        case ($urandom_range(0, 11))
          0:       b = 8'h77;
          1:       b = 8'hff;
          2:       b = 8'h88;
          3:       b = 8'h00;
          default: b = 8'($urandom);
        endcase
      end
      push_byte(b, mark_end && (i == n - 1));
    end
  endtask

  // Short run of random bytes; always ends on a marked byte so the next block starts clean
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      push_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 15) == 0));
  endtask

  // Mostly blocks (whole or cut short by last_byte), some noise
  task automatic run_mix(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      if ($urandom_range(0, 99) < 75) begin
        if (eff_len > 256)
          send_block($urandom_range(1, 200), 1'b1);
        else if ($urandom_range(0, 3) == 0)
          send_block($urandom_range(1, eff_len), 1'b1);
        else
          send_block(eff_len, $urandom_range(0, 3) == 0);
      end else begin
        send_noise($urandom_range(1, 12));
      end
    end
  endtask

  // Directed block at the reset length: both predictor extremes, clamped and
  // oversized step index, every nibble code, saturation both ways
  logic [7:0] directed_bytes [23] = '{
    8'h00, 8'h80, 8'd88,  8'hff,
    8'hff, 8'h7f, 8'd200, 8'h00,
    8'h88, 8'h88, 8'hff,  8'h10,
    8'h00, 8'h77, 8'h77,  8'h32,
    8'h54, 8'h76, 8'h98,  8'hba,
    8'hdc, 8'hfe, 8'h01
  };

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idle(IDLE_NONE);
    foreach (directed_bytes[i]) push_byte(directed_bytes[i], i == 22);
    wait_drained();

    // Smallest legal block
    write_align(13'd16);
    run_mix(250);
    wait_drained();

    // Degenerate lengths: every byte is header byte 0
    write_align(13'd0);
    set_idle(IDLE_SEND);
    send_noise(30);
    wait_drained();

    write_align(13'd1);
    set_idle(IDLE_BOTH);
    send_noise(30);
    wait_drained();

    // Length not a multiple of 8
    write_align(13'd13);
    set_idle(IDLE_RECV);
    run_mix(250);
    wait_drained();

    // Oversized length clamps to the maximum
    write_align(13'h1fff);
    set_idle(IDLE_NONE);
    send_block(120, 1'b0);
    send_block(40, 1'b1);
    wait_drained();

    write_align(13'd4096);
    set_idle(IDLE_BOTH);
    run_mix(200);
    wait_drained();

    // Receiver holds off while the sender keeps pushing, so backpressure reaches in_stall
    write_align(13'd64);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    run_mix(250);
    wait_drained();

    write_align(13'(8 * $urandom_range(2, 64)));
    set_idle(IDLE_RECV);
    run_mix(250);
    wait_drained();

    // Sender pauses mid-phase until every owed word is out
    write_align(13'd24);
    set_idle(IDLE_SEND);
    run_mix(100);
    wait_drained();
    run_mix(100);
    wait_drained();

    if (fail_count == 0 && pending_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #16_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
